### hdl/ght_pkg.sv
// Shared types and register codes for the thinning pass block.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

    // Width of the geometry configuration registers
    localparam int CFG_DIM_W = 11;

    // Output queue depth and its pointer width
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = 2;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SUB_PASS     = 2'd2
    } ght_reg_e;

    // Control info for one item travelling from the counter stage to the window stage
    typedef struct packed {
        logic valid;
        logic pix;
        logic primed;
        logic interior;
        logic last;
    } ght_item_t;

    // One result beat
    typedef struct packed {
        logic frame_end;
        logic deleted;
        logic pixel_out;
    } ght_result_t;

endpackage

`default_nettype wire

### hdl/ght_line_mem.sv
// Two-row line store: one synchronous memory, bit 1 upper row, bit 0 middle row.
// Forwards a write that lands on the address read in the same cycle. Uses ght_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ght_line_mem
    import ght_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output logic      [1:0]                   rd_data,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  wire logic [1:0]                   wr_data
);

    logic [1:0] mem [MAX_WIDTH];
    logic [1:0] mem_q_reg;
    logic [1:0] fwd_data_reg;
    logic       fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

endmodule

`default_nettype wire

### hdl/ght_ctrl.sv
// Position counters: input column/row, output row/column, priming, border and
// end-of-frame decisions. Issues the line store read. Uses ght_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ght_ctrl
    import ght_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          op,
    input  wire logic                          pixel_in,
    input  wire logic                          restart,
    input  wire logic [CFG_DIM_W-1:0]          cfg_width,
    input  wire logic [CFG_DIM_W-1:0]          cfg_height,
    output logic      [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    output ght_item_t                          item,
    output logic      [$clog2(MAX_WIDTH)-1:0]  item_col
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1) + 1;
    localparam int RB = $clog2(MAX_HEIGHT);
    localparam int HB = $clog2(MAX_HEIGHT + 1) + 1;

    logic [CW-1:0] in_col_reg, in_col_next;
    logic [1:0]    in_row_reg, in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RB-1:0] out_row_reg, out_row_next;
    ght_item_t     item_reg, item_next;
    logic [CW-1:0] col_reg;

    logic [WB-1:0] w;
    logic [HB-1:0] h;
    logic [CW-1:0] col;
    logic          primed;
    logic          interior;
    logic          last;
    logic          in_wrap;
    logic          out_wrap;

    // Clamp geometry to [3, MAX]
    always_comb
    begin
        if (cfg_width < CFG_DIM_W'(3))
        begin
            w = WB'(3);
        end
        else if (32'(cfg_width) > MAX_WIDTH)
        begin
            w = WB'(MAX_WIDTH);
        end
        else
        begin
            w = WB'(cfg_width);
        end
        if (cfg_height < CFG_DIM_W'(3))
        begin
            h = HB'(3);
        end
        else if (32'(cfg_height) > MAX_HEIGHT)
        begin
            h = HB'(MAX_HEIGHT);
        end
        else
        begin
            h = HB'(cfg_height);
        end
    end

    always_comb
    begin
        col      = (WB'(in_col_reg) >= w) ? CW'(w - WB'(1)) : in_col_reg;
        primed   = (in_row_reg >= 2'd2) || (in_row_reg == 2'd1 && in_col_reg != '0);
        in_wrap  = (WB'(in_col_reg) + WB'(1)) >= w;
        out_wrap = (WB'(out_col_reg) + WB'(1)) >= w;
        interior = (out_row_reg != '0) && ((HB'(out_row_reg) + HB'(2)) <= h)
                && (out_col_reg != '0) && ((WB'(out_col_reg) + WB'(2)) <= w);
        last     = ((HB'(out_row_reg) + HB'(1)) > h)
                || (((HB'(out_row_reg) + HB'(1)) == h) && out_wrap);
    end

    // Clear counters on restart, else advance them on each accepted beat
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        item_next    = '0;
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            item_next.valid    = 1'b1;
            item_next.pix      = !op && pixel_in;
            item_next.primed   = primed;
            item_next.interior = interior;
            item_next.last     = last;
            if (in_wrap)
            begin
                in_col_next = '0;
                if (in_row_reg != 2'd2)
                begin
                    in_row_next = in_row_reg + 2'd1;
                end
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (primed)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RB'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            item_reg    <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            item_reg    <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= col;
        end
    end

    assign rd_addr  = col;
    assign item     = item_reg;
    assign item_col = col_reg;

endmodule

`default_nettype wire

### hdl/ght_window.sv
// 3x3 window register, line store write-back and the Guo-Hall delete test.
// Uses ght_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ght_window
    import ght_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ght_item_t   item,
    input  wire logic [1:0]  rd_data,
    input  wire logic        sub_pass,
    output logic             wr_en,
    output logic [1:0]       wr_data,
    output logic             push,
    output ght_result_t      result
);

    logic [8:0] win_reg, win_next;
    logic       a, b;
    logic       p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [2:0] c, n1, n2, n;
    logic       m, del;

    always_comb
    begin
        a        = rd_data[1];
        b        = rd_data[0];
        win_next = {item.pix, win_reg[8:7], b, win_reg[5:4], a, win_reg[2:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (item.valid)
        begin
            win_reg <= win_next;
        end
    end

    // Upper row takes the old middle row, middle row takes the new pixel
    assign wr_en   = item.valid;
    assign wr_data = {b, item.pix};

    always_comb
    begin
        p9 = win_next[0];
        p2 = win_next[1];
        p3 = win_next[2];
        p8 = win_next[3];
        p1 = win_next[4];
        p4 = win_next[5];
        p7 = win_next[6];
        p6 = win_next[7];
        p5 = win_next[8];
        c  = 3'(!p2 && (p3 || p4)) + 3'(!p4 && (p5 || p6))
           + 3'(!p6 && (p7 || p8)) + 3'(!p8 && (p9 || p2));
        n1 = 3'(p9 || p2) + 3'(p3 || p4) + 3'(p5 || p6) + 3'(p7 || p8);
        n2 = 3'(p2 || p3) + 3'(p4 || p5) + 3'(p6 || p7) + 3'(p8 || p9);
        n  = (n1 < n2) ? n1 : n2;
        m  = sub_pass ? ((p2 || p3 || !p5) && p4) : ((p6 || p7 || !p9) && p8);
        del = item.interior && p1 && (c == 3'd1) && (n >= 3'd2) && (n <= 3'd3) && !m;
        result.pixel_out = p1 && !del;
        result.deleted   = del;
        result.frame_end = item.last;
    end

    assign push = item.valid && item.primed;

endmodule

`default_nettype wire

### hdl/ght_out_fifo.sv
// Small register queue that holds result beats while the sink stalls.
// Uses ght_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ght_out_fifo
    import ght_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ght_result_t   push_data,
    input  wire logic          pop,
    output logic               not_empty,
    output ght_result_t        head,
    output logic [OFIFO_AW:0]  count
);

    ght_result_t          slots [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [OFIFO_AW:0]    count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (OFIFO_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (OFIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OFIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OFIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = slots[rd_ptr_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire

### hdl/guo_hall_thinning_pass.sv
// Top level of the Guo-Hall thinning sub-pass: APB register file, stream ports and
// the counter, line store, window and output queue units. Uses ght_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata[0] pixel_in, tuser op (1 = drain)
// m_*       out  m_tvalid/m_tready  tdata[0] pixel_out, tdata[1] deleted, tlast frame_end
// apb       in   psel/penable       paddr 0 frame_width, 4 frame_height, 8 sub_pass
//
// One beat per clock sustained while the sink keeps draining the queue. A beat
// passes the counter stage (line store read issued), is registered into the window
// stage (read-modify-write of the line store) and then sits in a four-entry output
// queue. Results lag input by one row plus one pixel, so send frame_width+1 drain
// beats after a frame. s_tready drops only when the queue plus the window stage
// hold four beats. Reset needs no memory clearing pass: interior windows only see
// line store entries written earlier in the same frame.

module guo_hall_thinning_pass
    import ght_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] pixel_in, [7:1] zero
    input  wire logic        s_tuser,   // [0] op
    // stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [0] pixel_out, [1] deleted, [7:2] zero
    output logic             m_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CFG_DIM_W-1:0] frame_width_reg;
    logic [CFG_DIM_W-1:0] frame_height_reg;
    logic                 sub_pass_reg;

    logic                 accept;
    logic                 cfg_write;
    logic                 restart;
    ght_reg_e             reg_sel;

    logic [CW-1:0]        rd_addr;
    logic [CW-1:0]        item_col;
    ght_item_t            item;
    logic [1:0]           rd_data;
    logic                 wr_en;
    logic [1:0]           wr_data;
    logic                 push;
    ght_result_t          result;
    ght_result_t          head;
    logic                 pop;
    logic [OFIFO_AW:0]    fifo_count;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = ght_reg_e'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_DIM_W'(640);
            frame_height_reg <= CFG_DIM_W'(480);
            sub_pass_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_DIM_W-1:0];
                REG_SUB_PASS:     sub_pass_reg     <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // Geometry writes restart the frame
    always_comb
    begin
        restart = 1'b0;
        if (cfg_write)
        begin
            case (reg_sel)
                REG_FRAME_WIDTH:  restart = 1'b1;
                REG_FRAME_HEIGHT: restart = 1'b1;
                default:          restart = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            REG_SUB_PASS:     prdata = 32'(sub_pass_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stream handshake: hold off input once the queue could overflow
    // ------------------------------------------------------------------
    assign s_tready = (fifo_count + (OFIFO_AW+1)'(item.valid)) < (OFIFO_AW+1)'(OFIFO_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    ght_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (s_tuser),
        .pixel_in   (s_tdata[0]),
        .restart    (restart),
        .cfg_width  (frame_width_reg),
        .cfg_height (frame_height_reg),
        .rd_addr    (rd_addr),
        .item       (item),
        .item_col   (item_col)
    );

    ght_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (item_col),
        .wr_data (wr_data)
    );

    ght_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .rd_data  (rd_data),
        .sub_pass (sub_pass_reg),
        .wr_en    (wr_en),
        .wr_data  (wr_data),
        .push     (push),
        .result   (result)
    );

    ght_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .pop       (pop),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (fifo_count)
    );

    assign m_tdata = {6'b0, head.deleted, head.pixel_out};
    assign m_tlast = head.frame_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_reaches_window: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> item.valid)
        else $error("accepted beat did not reach the window stage");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> fifo_count < (OFIFO_AW+1)'(OFIFO_DEPTH))
        else $error("output queue overflow");

    a_deleted_clears_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        push && result.deleted |-> !result.pixel_out)
        else $error("deleted pixel still set");

    a_window_only_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid |-> $past(accept))
        else $error("window stage active without an accepted beat");

endmodule

`default_nettype wire
